FILE: hw/rtl/jha_pkg.sv
package jha_pkg;

    localparam int JOINT_COUNT = 7;
    localparam int ANGLE_BITS  = 16;
    localparam int FIELD_W     = 16;
    localparam int IDX_W       = 3;
    localparam int LANE_LAT    = 5;
    localparam int CNT_W       = 3;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    // wide enough for a lane product plus the rounding half
    localparam int PROD_W      = ANGLE_BITS + 18;

    localparam logic [CFG_IDX_W-1:0] REG_HOME_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VLIM_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VLIM_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd6;

    localparam logic [63:0] RST_HOME_LO = 64'd1775544153504219136;
    localparam logic [47:0] RST_HOME_HI = 48'd413401088;
    localparam logic [63:0] RST_VLIM_LO = 64'd1152939097061330944;
    localparam logic [47:0] RST_VLIM_HI = 48'd17592454483968;
    localparam logic [15:0] RST_GAIN    = 16'd1280;
    localparam logic [14:0] RST_TOL     = 15'd205;
    localparam logic [15:0] RST_STEP    = 16'd131;

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_TRIGGER = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    localparam logic RES_TICK = 1'b0;
    localparam logic RES_TRIG = 1'b1;

    typedef logic signed [ANGLE_BITS-1:0] t_ang;
    typedef logic signed [PROD_W-1:0]     t_wide;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [FIELD_W-1:0]  pos_0;
        logic signed [FIELD_W-1:0]  pos_1;
        logic signed [FIELD_W-1:0]  pos_2;
        logic signed [FIELD_W-1:0]  pos_3;
        logic signed [FIELD_W-1:0]  pos_4;
        logic signed [FIELD_W-1:0]  pos_5;
        logic signed [FIELD_W-1:0]  pos_6;
    } t_in_item;

    typedef struct packed {
        logic                       result_type;
        logic [IDX_W-1:0]           joint_index;
        logic signed [FIELD_W-1:0]  ref_velocity;
        logic signed [FIELD_W-1:0]  ref_position;
        logic signed [FIELD_W-1:0]  command_velocity;
        logic                       reference_valid;
        logic                       at_home;
        logic                       homing_success;
        logic                       last_result;
    } t_out_item;

    typedef struct packed {
        logic go;
        logic trig;
        logic pose;
        logic both;
        logic success;
    } t_emit_cmd;

    function automatic t_ang sat_ang(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = {{(PROD_W-ANGLE_BITS+1){1'b0}}, {(ANGLE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[ANGLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[ANGLE_BITS-1:0];
        end
        return v[ANGLE_BITS-1:0];
    endfunction

    // add half an LSB, then floor shift
    function automatic t_wide rnd_shr(input t_wide v, input int unsigned s);
        t_wide half;
        half = t_wide'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

endpackage

FILE: hw/rtl/joint_homing_attractor_top.sv
// Joint sample: stored at acceptance, no result, next item taken the following cycle.
// Homing trigger: the command is registered in the emitter, then the response in the output
//   register; ready again once the emitter is no longer busy.
// Control tick: five-stage lane pipeline; results then leave one per cycle while the sink is
//   ready, and no new item is taken until the last joint's result is loaded.
// Reset (synchronous, active low) restores register defaults, clears angles and both flags.
module joint_homing_attractor_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  jha_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output jha_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [jha_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jha_pkg::CFG_W-1:0]           i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [jha_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_pose, n_pose;
    logic                       r_homing, n_homing;
    jha_pkg::t_ang              r_angle [jha_pkg::JOINT_COUNT];

    logic [63:0]                r_home_lo;
    logic [47:0]                r_home_hi;
    logic [63:0]                r_vlim_lo;
    logic [47:0]                r_vlim_hi;
    logic [15:0]                r_gain;
    logic [14:0]                r_tol;
    logic [15:0]                r_step;

    jha_pkg::t_ang              w_pos [7];
    jha_pkg::t_ang              w_vel [jha_pkg::JOINT_COUNT];
    jha_pkg::t_ang              w_rp  [jha_pkg::JOINT_COUNT];
    logic [jha_pkg::JOINT_COUNT-1:0] w_near;
    jha_pkg::t_emit_cmd         w_cmd;
    logic                       w_busy;
    logic                       w_acc;
    logic                       w_store;

    assign w_pos[0] = jha_pkg::t_ang'(i_in_data.pos_0);
    assign w_pos[1] = jha_pkg::t_ang'(i_in_data.pos_1);
    assign w_pos[2] = jha_pkg::t_ang'(i_in_data.pos_2);
    assign w_pos[3] = jha_pkg::t_ang'(i_in_data.pos_3);
    assign w_pos[4] = jha_pkg::t_ang'(i_in_data.pos_4);
    assign w_pos[5] = jha_pkg::t_ang'(i_in_data.pos_5);
    assign w_pos[6] = jha_pkg::t_ang'(i_in_data.pos_6);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pose   = r_pose;
        n_homing = r_homing;
        w_store  = 1'b0;
        w_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in_data.kind)
                        jha_pkg::KIND_SAMPLE: begin
                            w_store = 1'b1;
                            n_pose  = 1'b1;
                        end
                        jha_pkg::KIND_TRIGGER: begin
                            n_homing      = 1'b1;
                            w_cmd.go      = 1'b1;
                            w_cmd.trig    = 1'b1;
                            w_cmd.success = r_pose;
                            n_state       = S_WAIT;
                        end
                        jha_pkg::KIND_TICK: begin
                            n_cnt   = '0;
                            n_state = S_CALC;
                        end
                        default: ;
                    endcase
                end
            end
            S_CALC: begin
                if (r_cnt == jha_pkg::CNT_W'(jha_pkg::LANE_LAT - 1)) begin
                    w_cmd.go   = 1'b1;
                    w_cmd.pose = r_pose;
                    w_cmd.both = r_pose && r_homing;
                    n_state    = S_WAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WAIT: begin
                if (!w_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pose    <= 1'b0;
            r_homing  <= 1'b0;
            r_home_lo <= jha_pkg::RST_HOME_LO;
            r_home_hi <= jha_pkg::RST_HOME_HI;
            r_vlim_lo <= jha_pkg::RST_VLIM_LO;
            r_vlim_hi <= jha_pkg::RST_VLIM_HI;
            r_gain    <= jha_pkg::RST_GAIN;
            r_tol     <= jha_pkg::RST_TOL;
            r_step    <= jha_pkg::RST_STEP;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pose   <= n_pose;
            r_homing <= n_homing;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    jha_pkg::REG_HOME_LO: r_home_lo <= i_cfg_data;
                    jha_pkg::REG_HOME_HI: r_home_hi <= i_cfg_data[47:0];
                    jha_pkg::REG_VLIM_LO: r_vlim_lo <= i_cfg_data;
                    jha_pkg::REG_VLIM_HI: r_vlim_hi <= i_cfg_data[47:0];
                    jha_pkg::REG_GAIN:    r_gain    <= i_cfg_data[15:0];
                    jha_pkg::REG_TOL:     r_tol     <= i_cfg_data[14:0];
                    jha_pkg::REG_STEP:    r_step    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // angle store: reset clears, a sample overwrites every joint
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < jha_pkg::JOINT_COUNT; j++) begin
            if (!i_rst_n) begin
                r_angle[j] <= '0;
            end else if (w_store) begin
                r_angle[j] <= w_pos[j];
            end
        end
    end

    for (genvar j = 0; j < jha_pkg::JOINT_COUNT; j++) begin : g_lane
        logic [15:0] w_home_slot;
        logic [15:0] w_lim_slot;
        if (j < 4) begin : g_lo
            assign w_home_slot = r_home_lo[16*j +: 16];
            assign w_lim_slot  = r_vlim_lo[16*j +: 16];
        end else begin : g_hi
            assign w_home_slot = r_home_hi[16*(j-4) +: 16];
            assign w_lim_slot  = r_vlim_hi[16*(j-4) +: 16];
        end

        jha_lane u_lane (
            .i_clk    (i_clk),
            .i_home   (jha_pkg::t_ang'($signed(w_home_slot))),
            .i_angle  (r_angle[j]),
            .i_limit  (w_lim_slot),
            .i_gain   (r_gain),
            .i_step   (r_step),
            .i_tol    (r_tol),
            .o_vel    (w_vel[j]),
            .o_refpos (w_rp[j]),
            .o_near   (w_near[j])
        );
    end

    jha_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_vel       (w_vel),
        .i_rp        (w_rp),
        .i_near      (w_near),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hw/rtl/jha_lane.sv
module jha_lane (
    input  logic             i_clk,
    input  jha_pkg::t_ang    i_home,
    input  jha_pkg::t_ang    i_angle,
    input  logic [15:0]      i_limit,
    input  logic [15:0]      i_gain,
    input  logic [15:0]      i_step,
    input  logic [14:0]      i_tol,
    output jha_pkg::t_ang    o_vel,
    output jha_pkg::t_ang    o_refpos,
    output logic             o_near
);

    localparam int P1_W = jha_pkg::ANGLE_BITS + 17;

    jha_pkg::t_ang                      r_err;
    logic signed [P1_W-1:0]             r_prod1;
    jha_pkg::t_ang                      r_vraw;
    logic                               r_near;
    logic signed [P1_W-1:0]             r_prod2;
    jha_pkg::t_ang                      r_vcl;
    jha_pkg::t_ang                      r_vout;
    jha_pkg::t_ang                      r_rp;

    jha_pkg::t_wide                     w_diff;
    jha_pkg::t_wide                     w_vw;
    jha_pkg::t_wide                     w_lw;
    jha_pkg::t_wide                     w_vc;
    logic [jha_pkg::ANGLE_BITS-1:0]     w_abs;
    jha_pkg::t_ang                      w_stepq;

    always_comb begin
        w_diff = jha_pkg::t_wide'(i_home) - jha_pkg::t_wide'(i_angle);
        w_abs  = r_err[jha_pkg::ANGLE_BITS-1] ? (~r_err + 1'b1) : r_err;
        w_vw   = jha_pkg::t_wide'(r_vraw);
        w_lw   = jha_pkg::t_wide'($signed({1'b0, i_limit}));
        if (w_vw > w_lw) begin
            w_vc = w_lw;
        end else if (w_vw < -w_lw) begin
            w_vc = -w_lw;
        end else begin
            w_vc = w_vw;
        end
        w_stepq = jha_pkg::sat_ang(jha_pkg::rnd_shr(jha_pkg::t_wide'(r_prod2), 16));
    end

    always_ff @(posedge i_clk) begin
        r_err   <= jha_pkg::sat_ang(w_diff);
        r_prod1 <= r_err * $signed({1'b0, i_gain});
        r_vraw  <= jha_pkg::sat_ang(jha_pkg::rnd_shr(jha_pkg::t_wide'(r_prod1), 8));
        r_near  <= (jha_pkg::PROD_W'(w_abs) < jha_pkg::PROD_W'(i_tol));
        r_prod2 <= r_vraw * $signed({1'b0, i_step});
        r_vcl   <= jha_pkg::sat_ang(w_vc);
        r_vout  <= r_vcl;
        r_rp    <= jha_pkg::sat_ang(jha_pkg::t_wide'(i_angle) + jha_pkg::t_wide'(w_stepq));
    end

    assign o_vel    = r_vout;
    assign o_refpos = r_rp;
    assign o_near   = r_near;

endmodule

FILE: hw/rtl/jha_emit.sv
module jha_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jha_pkg::t_emit_cmd                  i_cmd,
    input  jha_pkg::t_ang                       i_vel [jha_pkg::JOINT_COUNT],
    input  jha_pkg::t_ang                       i_rp  [jha_pkg::JOINT_COUNT],
    input  logic [jha_pkg::JOINT_COUNT-1:0]     i_near,
    output logic                                o_busy,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output jha_pkg::t_out_item                  o_out_data
);

    localparam logic [jha_pkg::IDX_W-1:0] LAST_IDX = jha_pkg::IDX_W'(jha_pkg::JOINT_COUNT - 1);

    logic                       r_busy, n_busy;
    logic [jha_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                       r_trig, n_trig;
    logic                       r_pose, n_pose;
    logic                       r_both, n_both;
    logic                       r_succ, n_succ;
    logic                       r_home, n_home;
    logic                       r_out_valid, n_out_valid;
    jha_pkg::t_out_item         r_out, n_out;

    logic                       w_load;
    logic                       w_last;
    jha_pkg::t_ang              w_vel;
    jha_pkg::t_ang              w_rp;

    always_comb begin
        w_load = r_busy && (!r_out_valid || i_out_ready);
        w_last = (r_idx == LAST_IDX);
        w_vel  = i_vel[r_idx];
        w_rp   = i_rp[r_idx];

        n_busy      = r_busy;
        n_idx       = r_idx;
        n_trig      = r_trig;
        n_pose      = r_pose;
        n_both      = r_both;
        n_succ      = r_succ;
        n_home      = r_home;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (r_trig) begin
                n_out.result_type    = jha_pkg::RES_TRIG;
                n_out.homing_success = r_succ;
                n_out.last_result    = 1'b1;
                n_busy               = 1'b0;
            end else begin
                n_out.result_type      = jha_pkg::RES_TICK;
                n_out.joint_index      = r_idx;
                n_out.ref_velocity     = r_pose ? w_vel[jha_pkg::FIELD_W-1:0] : '0;
                n_out.ref_position     = r_pose ? w_rp[jha_pkg::FIELD_W-1:0] : '0;
                n_out.command_velocity = r_both ? w_vel[jha_pkg::FIELD_W-1:0] : '0;
                n_out.reference_valid  = r_pose;
                n_out.at_home          = r_both ? r_home : 1'b1;
                n_out.last_result      = w_last;
                if (w_last) begin
                    n_busy = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end
        if (i_cmd.go) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_trig = i_cmd.trig;
            n_pose = i_cmd.pose;
            n_both = i_cmd.both;
            n_succ = i_cmd.success;
            // all errors under tolerance is the same as the max under it
            n_home = &i_near;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
        r_trig <= n_trig;
        r_pose <= n_pose;
        r_both <= n_both;
        r_succ <= n_succ;
        r_home <= n_home;
        r_out  <= n_out;
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/jha_checker.sv
module jha_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input jha_pkg::t_in_item    i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input jha_pkg::t_out_item   o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output item changed while stalled");

    // trigger response is a single-item run
    a_trig_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_type == jha_pkg::RES_TRIG |->
            o_out_data.last_result && o_out_data.joint_index == '0)
        else $error("trigger response malformed");

    // no pose yet: all motion fields quiet and at_home forced
    a_no_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_type == jha_pkg::RES_TICK &&
            !o_out_data.reference_valid |->
            o_out_data.ref_velocity == '0 && o_out_data.ref_position == '0 &&
            o_out_data.command_velocity == '0 && o_out_data.at_home)
        else $error("tick result before pose not zeroed");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == jha_pkg::KIND_TICK |=> !o_in_ready)
        else $error("new item taken during tick processing");

endmodule

bind joint_homing_attractor_top jha_checker u_jha_checker (.*);
